### rtl/core/kwmd_pkg.sv
`default_nettype none
package kwmd_pkg;
  localparam int unsigned MaxSources = 8;
  localparam int unsigned CfgAddrBits = 3;
  localparam logic [CfgAddrBits-1:0] RegNumSources = 3'd0;
  localparam logic [CfgAddrBits-1:0] RegEntriesPerFile = 3'd4;
  localparam logic [3:0] NumSourcesReset = 4'd8;
  localparam logic [15:0] EntriesPerFileReset = 16'd1024;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;
  localparam logic [1:0] StRead = 2'd3;
endpackage
`default_nettype wire

### rtl/core/kwmd_stream_if.sv
`default_nettype none
interface kwmd_stream_if #(
  parameter int unsigned W = 8
);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/kway_merge_dedup_compactor.sv
`default_nettype none
// A refill that completes the pending set starts a selection: StRead, then StScan
//   (one head memory read per active source), then StEmit registers the result.
// Other refills are only stored; a waiting result or a selection holds off input.
// The heads live in one synchronous memory swept once per selection.
// Reset (rst, synchronous): default registers, all active sources pending.
module kway_merge_dedup_compactor #(
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  kwmd_stream_if.sink in_ch,
  kwmd_stream_if.source out_ch,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [kwmd_pkg::CfgAddrBits-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import kwmd_pkg::*;
  localparam int unsigned MAX_SOURCES = MaxSources;
  localparam int unsigned SB = $clog2(MAX_SOURCES);
  localparam int unsigned HW = KEY_BITS + VALUE_BITS + 1;
  localparam int unsigned CB = $clog2(MAX_SOURCES + 1);

  logic [3:0] num_sources;
  logic [15:0] entries_per_file;
  logic [MAX_SOURCES-1:0] present, pending;
  logic [15:0] file_fill;
  logic [1:0] state;
  logic [SB-1:0] idx;
  logic found, win_tomb;
  logic [KEY_BITS-1:0] win_key;
  logic [VALUE_BITS-1:0] win_val;
  logic [MAX_SOURCES-1:0] consumed;
  logic [HW-1:0] mem [MAX_SOURCES];
  logic [HW-1:0] rd;
  logic [SB-1:0] rd_idx;
  logic [CB-1:0] act;
  logic [MAX_SOURCES-1:0] act_mask;
  logic out_valid;
  logic [KEY_BITS+VALUE_BITS+10:0] out_data;

  // payload: id[2:0], key, value, tomb, exh (LSB)
  logic [2:0] sid;
  logic [63:0] ikey, ival;
  logic itomb, iexh;
  assign {sid, ikey, ival, itomb, iexh} = in_ch.data;

  always_comb begin
    act = CB'(MAX_SOURCES);
    if (num_sources == 4'd0) act = CB'(1);
    else if (32'(num_sources) < MAX_SOURCES) act = CB'(num_sources);
    for (int i = 0; i < MAX_SOURCES; i++) act_mask[i] = (i < int'(act));
  end

  logic sid_ok;
  assign sid_ok = (32'(sid) < 32'(act)) && pending[SB'(sid)];
  assign in_ch.ready = (state == StIdle) && !out_valid;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    case (paddr)
      RegNumSources: prdata = {28'd0, num_sources};
      RegEntriesPerFile: prdata = {16'd0, entries_per_file};
      default: prdata = '0;
    endcase
  end

  // head memory
  always_ff @(posedge clk) begin
    if (acc && sid_ok && !iexh)
      mem[SB'(sid)] <= {KEY_BITS'(ikey), VALUE_BITS'(ival), itomb};
    rd <= mem[idx];
    rd_idx <= idx;
  end

  logic [KEY_BITS-1:0] rk;
  logic [VALUE_BITS-1:0] rv;
  logic rt;
  assign {rk, rv, rt} = rd;
  logic [15:0] limit, fill_inc;
  assign limit = (entries_per_file == 16'd0) ? 16'd1 : entries_per_file;
  assign fill_inc = file_fill + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sources <= NumSourcesReset;
      entries_per_file <= EntriesPerFileReset;
      present <= '0;
      file_fill <= '0;
      state <= StIdle;
      out_valid <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      pending <= MAX_SOURCES'({MAX_SOURCES{1'b1}});
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (cfg_wr && paddr == RegEntriesPerFile) entries_per_file <= pwdata[15:0];
      if (cfg_wr && paddr == RegNumSources) begin
        num_sources <= pwdata[3:0];
        present <= '0;
        file_fill <= '0;
        for (int i = 0; i < MAX_SOURCES; i++)
          pending[i] <= (pwdata[3:0] == 4'd0) ? (i == 0) : (i < int'(pwdata[3:0]));
      end else begin
        case (state)
          StIdle: if (acc && sid_ok) begin
            present[SB'(sid)] <= !iexh;
            pending[SB'(sid)] <= 1'b0;
            if ((pending & ~(MAX_SOURCES'(1) << sid)) == '0) begin
              state <= StRead;
              idx <= '0;
              found <= 1'b0;
              consumed <= '0;
            end
          end
          StRead: begin
            state <= StScan;
            if (32'(idx) + 1 < 32'(act)) idx <= idx + SB'(1);
          end
          StScan: begin
            if (present[rd_idx] && act_mask[rd_idx]) begin
              if (!found || rk < win_key) begin
                found <= 1'b1; win_key <= rk; win_val <= rv; win_tomb <= rt;
                consumed <= MAX_SOURCES'(1) << rd_idx;
              end else if (rk == win_key) begin
                win_val <= rv; win_tomb <= rt;
                consumed <= consumed | (MAX_SOURCES'(1) << rd_idx);
              end
            end
            if (32'(rd_idx) + 1 >= 32'(act)) state <= StEmit;
            else if (32'(idx) + 1 < 32'(act)) idx <= idx + SB'(1);
          end
          StEmit: begin
            state <= StIdle;
            out_valid <= 1'b1;
            if (!found) begin
              out_data <= {KEY_BITS'(0), VALUE_BITS'(0), 1'b0, 8'd0, file_fill != 0, 1'b1};
              file_fill <= '0;
            end else begin
              present <= present & ~consumed;
              pending <= consumed;
              if (win_tomb)
                out_data <= {win_key, VALUE_BITS'(0), 1'b0, 8'(consumed), 1'b0, 1'b0};
              else begin
                out_data <= {win_key, win_val, 1'b1, 8'(consumed), fill_inc >= limit, 1'b0};
                file_fill <= (fill_inc >= limit) ? 16'd0 : fill_inc;
              end
            end
          end
          default: state <= StIdle;
        endcase
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data = {64'(out_data[KEY_BITS+VALUE_BITS+10:VALUE_BITS+11]),
                        64'(out_data[VALUE_BITS+10:11]), out_data[10:0]};

  a_emit_empties: assert property (@(posedge clk) disable iff (rst)
    state == StEmit && found |=> pending != '0) else $error("pending lost");
  a_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    state != StIdle |-> !in_ch.ready) else $error("ready while busy");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    $past(state) == StEmit && out_valid && out_data[1] |-> file_fill == 16'd0)
    else $error("fill not cleared");
endmodule
`default_nettype wire
